// ===== sv/bdd_pkg.sv =====
// bdd_pkg: shared types and constants for the binary to decimal digits unit.
// No dependencies.
`default_nettype none

package bdd_pkg;

    localparam int DIGIT_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic convert;
        logic skip;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_bit;
        logic skip_done;
        logic one_left;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/binary_to_decimal_digits_unit.sv =====
// binary_to_decimal_digits_unit: top level, binary value in, decimal digits out.
// Depends on bdd_pkg, bdd_ctrl and bdd_datapath.
//
// Input channel: in_valid/in_stall with value. One request is taken at an edge
// where in_valid is high and in_stall low; in_stall is high while a value is
// being converted or its digits are still being sent.
// Output channel: out_valid/out_stall with digit and last. A value gives its
// decimal digits most significant first, no leading zeros, last set on the
// final digit; zero gives the single digit 0.
// Sequence: shift-add-3 over the VALUE_BITS bits of the value into NDIG digits
// (NDIG = digits of 2^VALUE_BITS-1), then leading zeros dropped, then one
// digit per cycle while the receiver does not stall. A new request is taken
// only after the final digit has entered the output register.
// A stalled digit holds in the output register and halts digit emission; the
// next request may be accepted while the final digit still waits.
// Reset clears the state machine and the output valid; no request in flight
// survives it.
`default_nettype none

module binary_to_decimal_digits_unit
#(
    parameter int VALUE_BITS = 63
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_BITS-1:0]  value,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [bdd_pkg::DIGIT_W-1:0] digit,
    output logic                        last
);

    bdd_pkg::cmd_t    cmd;
    bdd_pkg::status_t status;

    bdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bdd_datapath
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digit     (digit),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== sv/bdd_ctrl.sv =====
// bdd_ctrl: sequencing state machine (load, convert, drop leading zeros, emit).
// Depends on bdd_pkg.
`default_nettype none

module bdd_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire bdd_pkg::status_t status,
    output bdd_pkg::cmd_t        cmd
);

    bdd_pkg::state_t state_reg;
    bdd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bdd_pkg::ST_CONV;
                end
            end
            bdd_pkg::ST_CONV:
            begin
                if (status.last_bit)
                begin
                    state_next = bdd_pkg::ST_SKIP;
                end
            end
            bdd_pkg::ST_SKIP:
            begin
                if (status.skip_done)
                begin
                    state_next = bdd_pkg::ST_EMIT;
                end
            end
            bdd_pkg::ST_EMIT:
            begin
                if (status.out_free && status.one_left)
                begin
                    state_next = bdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != bdd_pkg::ST_IDLE);
        cmd.load    = (state_reg == bdd_pkg::ST_IDLE) && in_valid;
        cmd.convert = (state_reg == bdd_pkg::ST_CONV);
        cmd.skip    = (state_reg == bdd_pkg::ST_SKIP) && !status.skip_done;
        cmd.emit    = (state_reg == bdd_pkg::ST_EMIT) && status.out_free;
    end

endmodule

`default_nettype wire

// ===== sv/bdd_datapath.sv =====
// bdd_datapath: shift-add-3 converter, digit counter and output register.
// Depends on bdd_pkg.
`default_nettype none

module bdd_datapath
#(
    parameter int VALUE_BITS = 63
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VALUE_BITS-1:0]  value,
    input  wire bdd_pkg::cmd_t          cmd,
    output bdd_pkg::status_t            status,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [bdd_pkg::DIGIT_W-1:0] digit,
    output logic                        last
);

    localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * bdd_pkg::DIGIT_W;
    localparam int BCNT_W = $clog2(VALUE_BITS + 1);
    localparam int DCNT_W = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0]       value_reg;
    logic [BCD_W-1:0]            bcd_reg;
    logic [BCD_W-1:0]            bcd_adj;
    logic [BCNT_W-1:0]           bit_cnt_reg;
    logic [DCNT_W-1:0]           dig_cnt_reg;
    logic                        out_valid_reg;
    logic [bdd_pkg::DIGIT_W-1:0] digit_reg;
    logic                        last_reg;
    logic [bdd_pkg::DIGIT_W-1:0] top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: bdd_pkg::DIGIT_W];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        logic [bdd_pkg::DIGIT_W-1:0] d;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[i*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W];
            bcd_adj[i*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] =
                (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        status.last_bit  = (bit_cnt_reg == BCNT_W'(1));
        status.one_left  = (dig_cnt_reg == DCNT_W'(1));
        status.skip_done = (top_digit != '0) || status.one_left;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg   <= value;
            bcd_reg     <= '0;
            bit_cnt_reg <= BCNT_W'(VALUE_BITS);
            dig_cnt_reg <= DCNT_W'(NDIG);
        end
        else if (cmd.convert)
        begin
            bcd_reg     <= {bcd_adj[BCD_W-2:0], value_reg[VALUE_BITS-1]};
            value_reg   <= {value_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - BCNT_W'(1);
        end
        else if (cmd.skip || cmd.emit)
        begin
            bcd_reg     <= {bcd_reg[BCD_W-bdd_pkg::DIGIT_W-1:0], {bdd_pkg::DIGIT_W{1'b0}}};
            dig_cnt_reg <= dig_cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            digit_reg <= top_digit;
            last_reg  <= status.one_left;
        end
    end

    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign last      = last_reg;

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_reg <= 4'd9))
        else $error("emitted digit out of range");

    a_skip_zero_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip |-> ((top_digit == '0) && (dig_cnt_reg > DCNT_W'(1))))
        else $error("dropped a significant digit");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (dig_cnt_reg != '0))
        else $error("digit emitted past end of run");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.convert, cmd.skip, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire
